// File: rtl/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// shared widths, register map and normal codes for the swept box collision test
// ----------------------------------------------------------------------------
package sbc_pkg;

    localparam int POS_W   = 32;
    localparam int SIZE_W  = 31;
    localparam int TS_W    = 24;
    localparam int EDGE_W  = 35;
    localparam int PROD_W  = POS_W + TS_W + 1;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;
    localparam int NORM_W  = 2;
    localparam int ET_W    = 16;

    typedef enum logic [ADDR_W-3:0] {
        REG_TIME_STEP = '0
    } t_reg_idx;

    localparam logic signed [NORM_W-1:0] NORM_POS  = 2'sb01;
    localparam logic signed [NORM_W-1:0] NORM_NEG  = 2'sb11;
    localparam logic signed [NORM_W-1:0] NORM_NONE = 2'sb00;

endpackage

// File: rtl/swept_box_collision_test.sv
// ----------------------------------------------------------------------------
// swept_box_collision_test
// swept box versus fixed box test by the ray slab method, fully pipelined
// ----------------------------------------------------------------------------
// input channel i_valid / o_ready carries one box pair per item; output
// channel o_valid / i_ready returns exactly one result item per input item,
// in order.
// throughput is one item per cycle while the receiver does not hold i_ready
// low. from acceptance to o_valid an item passes through three setup stages,
// one stage per quotient bit in the four slab dividers (FRAC_BITS + 35 bits),
// then slab, combine, hit, multiply and output stages.
// all stages advance together; when the receiver holds i_ready low with a
// result waiting, the whole pipeline freezes and o_ready falls, so nothing is
// lost or repeated. bubbles still move while the output register is empty.
// reset clears all valid bits and loads time_step with 1.0; no clearing
// pass is needed. the user must write time_step over the apb port only while
// the block is idle; the block does not enforce it. items sample it at acceptance.
// ----------------------------------------------------------------------------
module swept_box_collision_test #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sbc_pkg::ADDR_W-1:0]          paddr,
    input  logic [sbc_pkg::DATA_W-1:0]          pwdata,
    output logic [sbc_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [sbc_pkg::POS_W-1:0]    i_mover_pos_x,
    input  logic signed [sbc_pkg::POS_W-1:0]    i_mover_pos_y,
    input  logic [sbc_pkg::SIZE_W-1:0]          i_mover_size_x,
    input  logic [sbc_pkg::SIZE_W-1:0]          i_mover_size_y,
    input  logic signed [sbc_pkg::POS_W-1:0]    i_mover_vel_x,
    input  logic signed [sbc_pkg::POS_W-1:0]    i_mover_vel_y,
    input  logic signed [sbc_pkg::POS_W-1:0]    i_target_pos_x,
    input  logic signed [sbc_pkg::POS_W-1:0]    i_target_pos_y,
    input  logic [sbc_pkg::SIZE_W-1:0]          i_target_size_x,
    input  logic [sbc_pkg::SIZE_W-1:0]          i_target_size_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic signed [sbc_pkg::POS_W-1:0]    o_contact_x,
    output logic signed [sbc_pkg::POS_W-1:0]    o_contact_y,
    output logic signed [sbc_pkg::NORM_W-1:0]   o_normal_x,
    output logic signed [sbc_pkg::NORM_W-1:0]   o_normal_y,
    output logic [sbc_pkg::ET_W-1:0]            o_entry_time
);

    localparam int EW = sbc_pkg::EDGE_W;
    localparam int OW = sbc_pkg::POS_W + 1;
    localparam int PW = sbc_pkg::PROD_W;
    localparam int DW = sbc_pkg::PROD_W - FRAC_BITS;
    localparam int NW = sbc_pkg::EDGE_W + FRAC_BITS;
    localparam int QW = NW + 2;
    localparam int MW = FRAC_BITS + DW + 2;
    localparam int CW = MW + 1;
    localparam logic [63:0] ONE_W = 64'd1 << FRAC_BITS;
    localparam logic [sbc_pkg::TS_W-1:0] TS_RST = ONE_W[sbc_pkg::TS_W-1:0];
    localparam logic signed [QW-1:0] ONE_Q = $signed(ONE_W[QW-1:0]);
    localparam logic signed [QW-1:0] T_LO = {1'b1, {(QW-1){1'b0}}};
    localparam logic signed [QW-1:0] T_HI = {1'b0, {(QW-1){1'b1}}};
    localparam logic [FRAC_BITS-1:0] RND = '1;
    localparam logic signed [CW-1:0] S_MAX = CW'(32'h7FFF_FFFF);
    localparam logic signed [CW-1:0] S_MIN = -S_MAX - CW'(1);

    typedef struct packed {
        logic signed [OW-1:0] ox;
        logic signed [OW-1:0] oy;
        logic [DW-1:0]        dmag_x;
        logic [DW-1:0]        dmag_y;
        logic                 dneg_x;
        logic                 dneg_y;
        logic                 lon_x;
        logic                 hin_x;
        logic                 in_x;
        logic                 lon_y;
        logic                 hin_y;
        logic                 in_y;
        logic                 vzero;
    } t_meta;

    typedef struct packed {
        logic                 ok;
        logic signed [QW-1:0] tn;
        logic signed [QW-1:0] tf;
    } t_slab;

    function automatic t_slab f_slab(input logic [NW-1:0] qa, input logic [NW-1:0] qb,
                                     input logic a_neg, input logic b_neg, input logic d_neg,
                                     input logic d_zero, input logic in_slab);
        t_slab                res;
        logic signed [QW-1:0] a;
        logic signed [QW-1:0] b;
        a = (a_neg ^ d_neg) ? -$signed({2'b00, qa}) : $signed({2'b00, qa});
        b = (b_neg ^ d_neg) ? -$signed({2'b00, qb}) : $signed({2'b00, qb});
        if (d_zero) begin
            res.ok = in_slab;
            res.tn = T_LO;
            res.tf = T_HI;
        end else if (a > b) begin
            res.ok = 1'b1;
            res.tn = b;
            res.tf = a;
        end else begin
            res.ok = 1'b1;
            res.tn = a;
            res.tf = b;
        end
        return res;
    endfunction

    logic [sbc_pkg::TS_W-1:0] time_step;
    logic                     en;

    sbc_cfg #(
        .RESET_VAL (TS_RST)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_time_step (time_step)
    );

    // stage 1: centres, grown corners, velocity products
    logic                     r1_vld;
    logic signed [OW-1:0]     r1_ox, r1_oy, r1_lox, r1_loy;
    logic [sbc_pkg::POS_W-1:0] r1_sx, r1_sy;
    logic signed [PW-1:0]     r1_pvx, r1_pvy;
    logic                     r1_vzero;
    logic signed [OW-1:0]     n1_ox, n1_oy, n1_lox, n1_loy;
    logic signed [PW-1:0]     n1_pvx, n1_pvy;

    always_comb begin
        n1_ox  = i_mover_pos_x + $signed({2'b00, i_mover_size_x[sbc_pkg::SIZE_W-1:1]});
        n1_oy  = i_mover_pos_y + $signed({2'b00, i_mover_size_y[sbc_pkg::SIZE_W-1:1]});
        n1_lox = i_target_pos_x - $signed({2'b00, i_mover_size_x[sbc_pkg::SIZE_W-1:1]});
        n1_loy = i_target_pos_y - $signed({2'b00, i_mover_size_y[sbc_pkg::SIZE_W-1:1]});
        n1_pvx = i_mover_vel_x * $signed({1'b0, time_step});
        n1_pvy = i_mover_vel_y * $signed({1'b0, time_step});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ox    <= n1_ox;
            r1_oy    <= n1_oy;
            r1_lox   <= n1_lox;
            r1_loy   <= n1_loy;
            r1_sx    <= {1'b0, i_target_size_x} + {1'b0, i_mover_size_x};
            r1_sy    <= {1'b0, i_target_size_y} + {1'b0, i_mover_size_y};
            r1_pvx   <= n1_pvx;
            r1_pvy   <= n1_pvy;
            r1_vzero <= (i_mover_vel_x == '0) && (i_mover_vel_y == '0);
        end
    end

    // stage 2: slab edges relative to origin, direction magnitude
    logic                 r2_vld;
    logic signed [EW-1:0] r2_lo_x, r2_hi_x, r2_lo_y, r2_hi_y;
    logic [DW-1:0]        r2_dmag_x, r2_dmag_y;
    logic                 r2_dneg_x, r2_dneg_y;
    logic signed [OW-1:0] r2_ox, r2_oy;
    logic                 r2_vzero;
    logic [PW-1:0]        n2_pmag_x, n2_pmag_y;
    logic [DW-1:0]        n2_dmag_x, n2_dmag_y;

    always_comb begin
        n2_pmag_x = r1_pvx[PW-1] ? PW'(-r1_pvx) : PW'(r1_pvx);
        n2_pmag_y = r1_pvy[PW-1] ? PW'(-r1_pvy) : PW'(r1_pvy);
        n2_dmag_x = DW'(n2_pmag_x >> FRAC_BITS);
        n2_dmag_y = DW'(n2_pmag_y >> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_lo_x   <= r1_lox - r1_ox;
            r2_lo_y   <= r1_loy - r1_oy;
            r2_hi_x   <= r1_lox - r1_ox + $signed({1'b0, r1_sx});
            r2_hi_y   <= r1_loy - r1_oy + $signed({1'b0, r1_sy});
            r2_dmag_x <= n2_dmag_x;
            r2_dmag_y <= n2_dmag_y;
            r2_dneg_x <= r1_pvx[PW-1] && (n2_dmag_x != '0);
            r2_dneg_y <= r1_pvy[PW-1] && (n2_dmag_y != '0);
            r2_ox     <= r1_ox;
            r2_oy     <= r1_oy;
            r2_vzero  <= r1_vzero;
        end
    end

    // stage 3: edge magnitudes and signs
    logic          r3_vld;
    logic [EW-1:0] r3_mlo_x, r3_mhi_x, r3_mlo_y, r3_mhi_y;
    t_meta         r3_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_mlo_x       <= r2_lo_x[EW-1] ? EW'(-r2_lo_x) : EW'(r2_lo_x);
            r3_mhi_x       <= r2_hi_x[EW-1] ? EW'(-r2_hi_x) : EW'(r2_hi_x);
            r3_mlo_y       <= r2_lo_y[EW-1] ? EW'(-r2_lo_y) : EW'(r2_lo_y);
            r3_mhi_y       <= r2_hi_y[EW-1] ? EW'(-r2_hi_y) : EW'(r2_hi_y);
            r3_meta.ox     <= r2_ox;
            r3_meta.oy     <= r2_oy;
            r3_meta.dmag_x <= r2_dmag_x;
            r3_meta.dmag_y <= r2_dmag_y;
            r3_meta.dneg_x <= r2_dneg_x;
            r3_meta.dneg_y <= r2_dneg_y;
            r3_meta.lon_x  <= r2_lo_x[EW-1];
            r3_meta.hin_x  <= r2_hi_x[EW-1];
            r3_meta.in_x   <= r2_lo_x[EW-1] && !r2_hi_x[EW-1] && (r2_hi_x != '0);
            r3_meta.lon_y  <= r2_lo_y[EW-1];
            r3_meta.hin_y  <= r2_hi_y[EW-1];
            r3_meta.in_y   <= r2_lo_y[EW-1] && !r2_hi_y[EW-1] && (r2_hi_y != '0);
            r3_meta.vzero  <= r2_vzero;
        end
    end

    // slab dividers
    logic [NW-1:0] q_lo_x, q_hi_x, q_lo_y, q_hi_y;

    sbc_div_pipe #(.NUM_W(NW), .DEN_W(DW)) u_div_lo_x (
        .i_clk (i_clk), .i_en (en),
        .i_num ({r3_mlo_x, {FRAC_BITS{1'b0}}}), .i_den (r3_meta.dmag_x), .o_quo (q_lo_x)
    );
    sbc_div_pipe #(.NUM_W(NW), .DEN_W(DW)) u_div_hi_x (
        .i_clk (i_clk), .i_en (en),
        .i_num ({r3_mhi_x, {FRAC_BITS{1'b0}}}), .i_den (r3_meta.dmag_x), .o_quo (q_hi_x)
    );
    sbc_div_pipe #(.NUM_W(NW), .DEN_W(DW)) u_div_lo_y (
        .i_clk (i_clk), .i_en (en),
        .i_num ({r3_mlo_y, {FRAC_BITS{1'b0}}}), .i_den (r3_meta.dmag_y), .o_quo (q_lo_y)
    );
    sbc_div_pipe #(.NUM_W(NW), .DEN_W(DW)) u_div_hi_y (
        .i_clk (i_clk), .i_en (en),
        .i_num ({r3_mhi_y, {FRAC_BITS{1'b0}}}), .i_den (r3_meta.dmag_y), .o_quo (q_hi_y)
    );

    // side data travelling beside the dividers
    t_meta r_dmeta [NW];
    logic  r_dvld  [NW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NW; k++) begin
                r_dvld[k] <= 1'b0;
            end
        end else if (en) begin
            r_dvld[0] <= r3_vld;
            for (int k = 1; k < NW; k++) begin
                r_dvld[k] <= r_dvld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dmeta[0] <= r3_meta;
            for (int k = 1; k < NW; k++) begin
                r_dmeta[k] <= r_dmeta[k-1];
            end
        end
    end

    // stage 4: signed slab times
    logic  r4_vld;
    t_slab r4_sx, r4_sy;
    t_meta r4_meta;
    t_meta dm;

    assign dm = r_dmeta[NW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r_dvld[NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_sx   <= f_slab(q_lo_x, q_hi_x, dm.lon_x, dm.hin_x, dm.dneg_x,
                              dm.dmag_x == '0, dm.in_x);
            r4_sy   <= f_slab(q_lo_y, q_hi_y, dm.lon_y, dm.hin_y, dm.dneg_y,
                              dm.dmag_y == '0, dm.in_y);
            r4_meta <= dm;
        end
    end

    // stage 5: entry and exit times
    logic                 r5_vld;
    logic signed [QW-1:0] r5_tnear, r5_tfar;
    logic                 r5_miss, r5_xgt, r5_xlt;
    t_meta                r5_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_tnear <= (r4_sx.tn > r4_sy.tn) ? r4_sx.tn : r4_sy.tn;
            r5_tfar  <= (r4_sx.tf < r4_sy.tf) ? r4_sx.tf : r4_sy.tf;
            r5_miss  <= r4_meta.vzero || !r4_sx.ok || !r4_sy.ok ||
                        (r4_sx.tn > r4_sy.tf) || (r4_sy.tn > r4_sx.tf);
            r5_xgt   <= r4_sx.tn > r4_sy.tn;
            r5_xlt   <= r4_sx.tn < r4_sy.tn;
            r5_meta  <= r4_meta;
        end
    end

    // stage 6: hit decision, normal, signed direction
    logic                              r6_vld, r6_hit;
    logic [FRAC_BITS-1:0]              r6_tfr;
    logic [sbc_pkg::ET_W-1:0]          r6_et;
    logic signed [sbc_pkg::NORM_W-1:0] r6_nx, r6_ny;
    logic signed [DW:0]                r6_dx, r6_dy;
    logic signed [OW-1:0]              r6_ox, r6_oy;
    logic                              n6_hit;
    logic [FRAC_BITS+sbc_pkg::ET_W-1:0] n6_etw;

    always_comb begin
        n6_hit = !r5_miss && !r5_tfar[QW-1] && !r5_tnear[QW-1] && (r5_tnear < ONE_Q);
        n6_etw = {r5_tnear[FRAC_BITS-1:0], {sbc_pkg::ET_W{1'b0}}} >> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_hit <= n6_hit;
            r6_tfr <= r5_tnear[FRAC_BITS-1:0];
            r6_et  <= n6_etw[sbc_pkg::ET_W-1:0];
            r6_nx  <= (n6_hit && r5_xgt) ?
                      (r5_meta.dneg_x ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG) :
                      sbc_pkg::NORM_NONE;
            r6_ny  <= (n6_hit && r5_xlt) ?
                      (r5_meta.dneg_y ? sbc_pkg::NORM_POS : sbc_pkg::NORM_NEG) :
                      sbc_pkg::NORM_NONE;
            r6_dx  <= r5_meta.dneg_x ? -$signed({1'b0, r5_meta.dmag_x})
                                     : $signed({1'b0, r5_meta.dmag_x});
            r6_dy  <= r5_meta.dneg_y ? -$signed({1'b0, r5_meta.dmag_y})
                                     : $signed({1'b0, r5_meta.dmag_y});
            r6_ox  <= r5_meta.ox;
            r6_oy  <= r5_meta.oy;
        end
    end

    // stage 7: travel along the ray
    logic                              r7_vld, r7_hit;
    logic signed [MW-1:0]              r7_px, r7_py;
    logic [sbc_pkg::ET_W-1:0]          r7_et;
    logic signed [sbc_pkg::NORM_W-1:0] r7_nx, r7_ny;
    logic signed [OW-1:0]              r7_ox, r7_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
        end else if (en) begin
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_px  <= $signed({1'b0, r6_tfr}) * r6_dx;
            r7_py  <= $signed({1'b0, r6_tfr}) * r6_dy;
            r7_hit <= r6_hit;
            r7_et  <= r6_et;
            r7_nx  <= r6_nx;
            r7_ny  <= r6_ny;
            r7_ox  <= r6_ox;
            r7_oy  <= r6_oy;
        end
    end

    // output stage: truncate toward zero, add origin, saturate
    logic                              r_o_vld, r_o_hit;
    logic signed [sbc_pkg::POS_W-1:0]  r_o_cx, r_o_cy;
    logic signed [sbc_pkg::NORM_W-1:0] r_o_nx, r_o_ny;
    logic [sbc_pkg::ET_W-1:0]          r_o_et;
    logic signed [CW-1:0]              n_sx, n_sy, n_cx, n_cy;

    always_comb begin
        n_sx = (CW'(r7_px) + (r7_px[MW-1] ? $signed({1'b0, RND}) : CW'(0))) >>> FRAC_BITS;
        n_sy = (CW'(r7_py) + (r7_py[MW-1] ? $signed({1'b0, RND}) : CW'(0))) >>> FRAC_BITS;
        n_cx = n_sx + r7_ox;
        n_cy = n_sy + r7_oy;
        if (n_cx > S_MAX) begin
            n_cx = S_MAX;
        end else if (n_cx < S_MIN) begin
            n_cx = S_MIN;
        end
        if (n_cy > S_MAX) begin
            n_cy = S_MAX;
        end else if (n_cy < S_MIN) begin
            n_cy = S_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_hit <= r7_hit;
            r_o_cx  <= r7_hit ? n_cx[sbc_pkg::POS_W-1:0] : '0;
            r_o_cy  <= r7_hit ? n_cy[sbc_pkg::POS_W-1:0] : '0;
            r_o_nx  <= r7_nx;
            r_o_ny  <= r7_ny;
            r_o_et  <= r7_hit ? r7_et : '0;
        end
    end

    assign en           = !r_o_vld || i_ready;
    assign o_ready      = en;
    assign o_valid      = r_o_vld;
    assign o_hit        = r_o_hit;
    assign o_contact_x  = r_o_cx;
    assign o_contact_y  = r_o_cy;
    assign o_normal_x   = r_o_nx;
    assign o_normal_y   = r_o_ny;
    assign o_entry_time = r_o_et;

endmodule

// File: rtl/sbc_div_pipe.sv
// ----------------------------------------------------------------------------
// sbc_div_pipe
// unsigned restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module sbc_div_pipe #(
    parameter int NUM_W = 51,
    parameter int DEN_W = 41
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] num_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W:0]   trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
        end

        assign trial = {rem_in, num_in[NUM_W-1]};
        assign ge    = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
                r_num[k] <= num_in << 1;
                r_quo[k] <= {quo_in[NUM_W-2:0], ge};
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule

// File: rtl/sbc_cfg.sv
// ----------------------------------------------------------------------------
// sbc_cfg
// apb register slice holding the frame time step
// ----------------------------------------------------------------------------
module sbc_cfg #(
    parameter logic [23:0] RESET_VAL = 24'h010000
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sbc_pkg::ADDR_W-1:0]  paddr,
    input  logic [sbc_pkg::DATA_W-1:0]  pwdata,
    output logic [sbc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic [sbc_pkg::TS_W-1:0]    o_time_step
);

    logic [sbc_pkg::TS_W-1:0] r_ts;
    sbc_pkg::t_reg_idx        idx;

    assign idx    = sbc_pkg::t_reg_idx'(paddr[sbc_pkg::ADDR_W-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts <= RESET_VAL;
        end else if (psel && penable && pwrite && (idx == sbc_pkg::REG_TIME_STEP)) begin
            r_ts <= pwdata[sbc_pkg::TS_W-1:0];
        end
    end

    always_comb begin
        case (idx)
            sbc_pkg::REG_TIME_STEP: prdata = {{(sbc_pkg::DATA_W-sbc_pkg::TS_W){1'b0}}, r_ts};
            default:                prdata = '0;
        endcase
    end

    assign o_time_step = r_ts;

endmodule
